### sv/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse unit.
// No dependencies.
package mi3_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int ELEM_W = 32;
	localparam int COF_W = 64;
	localparam int DET_W = 98;
	localparam int QUO_W = 32;
	localparam int THR_W = 32;
	localparam logic [THR_W-1:0] THR_RESET = 32'd1;

	// cofactor k = a[i]*a[j] - a[u]*a[v], entries {i, j, u, v}
	localparam int COF_IDX [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	typedef struct packed {
		logic signed [ELEM_W-1:0] m00;
		logic signed [ELEM_W-1:0] m01;
		logic signed [ELEM_W-1:0] m02;
		logic signed [ELEM_W-1:0] m10;
		logic signed [ELEM_W-1:0] m11;
		logic signed [ELEM_W-1:0] m12;
		logic signed [ELEM_W-1:0] m20;
		logic signed [ELEM_W-1:0] m21;
		logic signed [ELEM_W-1:0] m22;
	} in_word_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] r00;
		logic signed [ELEM_W-1:0] r01;
		logic signed [ELEM_W-1:0] r02;
		logic signed [ELEM_W-1:0] r10;
		logic signed [ELEM_W-1:0] r11;
		logic signed [ELEM_W-1:0] r12;
		logic signed [ELEM_W-1:0] r20;
		logic signed [ELEM_W-1:0] r21;
		logic signed [ELEM_W-1:0] r22;
		logic singular;
		logic saturated;
	} out_word_t;

	typedef struct packed {
		logic [8:0][ELEM_W-1:0] elem;
		logic [8:0][COF_W-1:0] cmag;
		logic [8:0] neg;
		logic [DET_W-1:0] dmag;
		logic singular;
	} front_rec_t;

endpackage

### sv/mi3_front.sv
// Front pipeline: cofactors, determinant, magnitudes and singular test.
// Depends on mi3_pkg.
module mi3_front import mi3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_word_t item,
	input  logic [THR_W-1:0] det_threshold,
	output front_rec_t rec,
	output logic rec_vld,
	input  logic q_full
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic signed [ELEM_W-1:0] a_s1 [9], a_s2 [9], a_s3 [9], a_s4 [9];
	logic signed [ELEM_W-1:0] a_s5 [9], a_s6 [9], a_s7 [9], a_s8 [9];
	logic signed [COF_W-1:0] p_s2 [18];
	logic signed [COF_W-1:0] c_s3 [9], c_s4 [9], c_s5 [9], c_s6 [9];
	logic signed [COF_W:0] pl_s4 [3];
	logic signed [COF_W-1:0] ph_s4 [3];
	logic signed [ELEM_W+COF_W-1:0] t_s5 [3];
	logic signed [DET_W-1:0] det_s6;
	logic [DET_W-1:0] dmag_s7, dmag_s8;
	logic [COF_W-1:0] cmag_s7 [9], cmag_s8 [9];
	logic [8:0] neg_s7, neg_s8;
	logic sing_s8;

	logic signed [COF_W-1:0] p_d [18];
	logic signed [COF_W:0] pl_d [3];
	logic signed [COF_W-1:0] ph_d [3];
	logic signed [ELEM_W+COF_W-1:0] t_d [3];
	logic signed [DET_W-1:0] det_d;
	logic [DET_W-1:0] lim;
	logic dneg;

	assign en = !v_s8 || !q_full;
	assign full = !en;
	assign rec_vld = v_s8;
	assign dneg = det_s6[DET_W-1];
	assign lim = {{(DET_W-THR_W){1'b0}}, det_threshold} << (2*FRAC_BITS);

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			p_d[2*k] = a_s1[COF_IDX[k][0]] * a_s1[COF_IDX[k][1]];
			p_d[2*k+1] = a_s1[COF_IDX[k][2]] * a_s1[COF_IDX[k][3]];
		end
		pl_d[0] = a_s3[0] * $signed({1'b0, c_s3[0][ELEM_W-1:0]});
		pl_d[1] = a_s3[1] * $signed({1'b0, c_s3[3][ELEM_W-1:0]});
		pl_d[2] = a_s3[2] * $signed({1'b0, c_s3[6][ELEM_W-1:0]});
		ph_d[0] = a_s3[0] * $signed(c_s3[0][COF_W-1:ELEM_W]);
		ph_d[1] = a_s3[1] * $signed(c_s3[3][COF_W-1:ELEM_W]);
		ph_d[2] = a_s3[2] * $signed(c_s3[6][COF_W-1:ELEM_W]);
		for (int k = 0; k < 3; k++) begin
			t_d[k] = $signed({ph_s4[k], {ELEM_W{1'b0}}})
				+ $signed({{(ELEM_W-1){pl_s4[k][COF_W]}}, pl_s4[k]});
		end
		det_d = $signed({{2{t_s5[0][ELEM_W+COF_W-1]}}, t_s5[0]})
			+ $signed({{2{t_s5[1][ELEM_W+COF_W-1]}}, t_s5[1]})
			+ $signed({{2{t_s5[2][ELEM_W+COF_W-1]}}, t_s5[2]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= item.m00;
			a_s1[1] <= item.m01;
			a_s1[2] <= item.m02;
			a_s1[3] <= item.m10;
			a_s1[4] <= item.m11;
			a_s1[5] <= item.m12;
			a_s1[6] <= item.m20;
			a_s1[7] <= item.m21;
			a_s1[8] <= item.m22;
			a_s2 <= a_s1;
			a_s3 <= a_s2;
			a_s4 <= a_s3;
			a_s5 <= a_s4;
			a_s6 <= a_s5;
			a_s7 <= a_s6;
			a_s8 <= a_s7;
			p_s2 <= p_d;
			for (int k = 0; k < 9; k++) begin
				c_s3[k] <= p_s2[2*k] - p_s2[2*k+1];
			end
			c_s4 <= c_s3;
			c_s5 <= c_s4;
			c_s6 <= c_s5;
			pl_s4 <= pl_d;
			ph_s4 <= ph_d;
			t_s5 <= t_d;
			det_s6 <= det_d;
			dmag_s7 <= dneg ? DET_W'(-det_s6) : DET_W'(det_s6);
			for (int k = 0; k < 9; k++) begin
				cmag_s7[k] <= c_s6[k][COF_W-1] ? COF_W'(-c_s6[k]) : COF_W'(c_s6[k]);
				neg_s7[k] <= c_s6[k][COF_W-1] ^ dneg;
			end
			dmag_s8 <= dmag_s7;
			cmag_s8 <= cmag_s7;
			neg_s8 <= neg_s7;
			sing_s8 <= dmag_s7 <= lim;
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			rec.elem[k] = a_s8[k];
			rec.cmag[k] = cmag_s8[k];
		end
		rec.neg = neg_s8;
		rec.dmag = dmag_s8;
		rec.singular = sing_s8;
	end

endmodule

### sv/mi3_queue.sv
// Small word queue between the front pipeline and the divider back end.
// Depends on mi3_pkg.
module mi3_queue import mi3_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  front_rec_t wdata,
	output logic q_full,
	input  logic rd,
	output front_rec_t rdata,
	output logic q_nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	front_rec_t mem [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr, do_rd;

	assign q_full = cnt_q == CNT_W'(DEPTH);
	assign q_nonempty = cnt_q != '0;
	assign do_wr = wr && !q_full;
	assign do_rd = rd && q_nonempty;
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/mi3_back.sv
// Back end: nine radix-2 restoring divider lanes, saturation, output register.
// Depends on mi3_pkg.
module mi3_back import mi3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  front_rec_t rec,
	input  logic rec_vld,
	output logic rec_pop,
	output out_word_t result,
	output logic empty,
	input  logic pop
);

	localparam int NW = COF_W + 2*FRAC_BITS;
	localparam int CNT_W = $clog2(QUO_W);
	localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] NEG_MAX = {1'b1, {(QUO_W-1){1'b0}}};

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [8:0][ELEM_W-1:0] elem_q;
	logic [8:0] neg_q;
	logic [DET_W-1:0] dmag_q;
	logic sing_q;
	out_word_t res_q;
	logic res_vld_q;

	logic load, run, out_free;
	logic [QUO_W-1:0] fin_val [9];
	logic [8:0] fin_sat;
	out_word_t res_d;

	assign load = (state_q == ST_IDLE) && rec_vld;
	assign run = state_q == ST_RUN;
	assign rec_pop = load;
	assign out_free = !res_vld_q || pop;
	assign result = res_q;
	assign empty = !res_vld_q;

	for (genvar i = 0; i < 9; i++) begin : g_lane
		logic [DET_W-1:0] rem_q;
		logic [QUO_W-1:0] nlo_q, quo_q;
		logic sat0_q;
		logic [NW-1:0] nfull;
		logic [DET_W-1:0] r0;
		logic [DET_W:0] t, diff;
		logic ge, lim_hit;

		assign nfull = {rec.cmag[i], {(2*FRAC_BITS){1'b0}}};
		assign r0 = {{(DET_W-NW+QUO_W){1'b0}}, nfull[NW-1:QUO_W]};
		assign t = {rem_q, nlo_q[QUO_W-1]};
		assign diff = t - {1'b0, dmag_q};
		assign ge = t >= {1'b0, dmag_q};
		assign lim_hit = neg_q[i] ? (quo_q > NEG_MAX) : (quo_q > POS_MAX);
		assign fin_sat[i] = sat0_q || lim_hit;
		assign fin_val[i] = fin_sat[i] ? (neg_q[i] ? NEG_MAX : POS_MAX)
			: (neg_q[i] ? QUO_W'(-quo_q) : quo_q);

		always_ff @(posedge clk) begin
			if (load) begin
				rem_q <= r0;
				nlo_q <= nfull[QUO_W-1:0];
				quo_q <= '0;
				sat0_q <= r0 >= rec.dmag;
			end else if (run) begin
				rem_q <= ge ? diff[DET_W-1:0] : t[DET_W-1:0];
				nlo_q <= {nlo_q[QUO_W-2:0], 1'b0};
				quo_q <= {quo_q[QUO_W-2:0], ge};
			end
		end
	end

	always_comb begin
		res_d.r00 = sing_q ? elem_q[0] : fin_val[0];
		res_d.r01 = sing_q ? elem_q[1] : fin_val[1];
		res_d.r02 = sing_q ? elem_q[2] : fin_val[2];
		res_d.r10 = sing_q ? elem_q[3] : fin_val[3];
		res_d.r11 = sing_q ? elem_q[4] : fin_val[4];
		res_d.r12 = sing_q ? elem_q[5] : fin_val[5];
		res_d.r20 = sing_q ? elem_q[6] : fin_val[6];
		res_d.r21 = sing_q ? elem_q[7] : fin_val[7];
		res_d.r22 = sing_q ? elem_q[8] : fin_val[8];
		res_d.singular = sing_q;
		res_d.saturated = !sing_q && (|fin_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (pop && res_vld_q) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rec_vld) begin
						cnt_q <= '0;
						state_q <= rec.singular ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W-1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_vld_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			elem_q <= rec.elem;
			neg_q <= rec.neg;
			dmag_q <= rec.dmag;
			sing_q <= rec.singular;
		end
		if (state_q == ST_FIN && out_free) begin
			res_q <= res_d;
		end
	end

endmodule

### sv/matrix3x3_inverse_unit.sv
// 3x3 fixed-point matrix inverse by the adjugate; top level.
// Depends on mi3_pkg, mi3_front, mi3_queue, mi3_back.
//
// One matrix word in, one result word out, in order. An eight-stage front
// pipeline takes a word every cycle unless a full queue stalls it, and
// forms the cofactors, the exact determinant and the singular test; a
// QUEUE_DEPTH-word queue then feeds one back end of nine restoring divider
// lanes that share a 32-step sequence. The back end takes a new matrix only
// after the last is finished: load, the 32 quotient steps, finish (a
// singular matrix skips the steps). det_threshold resets to 1; the user
// must write it only while idle, which the block itself does not enforce.
module matrix3x3_inverse_unit import mi3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_word_t item,
	output logic empty,
	input  logic pop,
	output out_word_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	logic [THR_W-1:0] thr_q;
	front_rec_t f_rec, q_rec;
	logic f_vld, q_full, q_nonempty, q_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.det_threshold(thr_q),
		.rec(f_rec),
		.rec_vld(f_vld),
		.q_full(q_full)
	);

	mi3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(f_vld),
		.wdata(f_rec),
		.q_full(q_full),
		.rd(q_rd),
		.rdata(q_rec),
		.q_nonempty(q_nonempty)
	);

	mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rec(q_rec),
		.rec_vld(q_nonempty),
		.rec_pop(q_rd),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

`ifndef SYNTHESIS
	a_no_stall_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		!q_full |-> !full)
		else $error("front stalled with queue room");

	a_singular_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.singular) |-> !result.saturated)
		else $error("singular word flagged saturated");

	a_pop_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_nonempty)
		else $error("back end read empty queue");
`endif

endmodule

### tb/tb_matrix3x3_inverse_unit.sv
// Testbench for matrix3x3_inverse_unit: random and directed matrices, with a
// bit-exact adjugate/determinant predictor and a queue of expected words.
// Depends on mi3_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_matrix3x3_inverse_unit;
	import mi3_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_word_t item = '0;
	logic empty;
	logic pop = 1'b0;
	out_word_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [THR_W-1:0] cfg_data = '0;

	matrix3x3_inverse_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	in_word_t pending_mats[$];
	out_word_t inverse_q[$];
	logic [31:0] threshold = THR_RESET;
	int errors = 0;
	int cycles = 0;
	int push_gap = 0;
	int pop_gap = 0;
	bit quiet = 1'b0;
	bit cfg_req = 1'b0;
	bit cfg_done = 1'b0;
	logic [31:0] cfg_value;

	function automatic out_word_t invert(in_word_t w, logic [31:0] thr);
		logic signed [31:0] a[9];
		logic signed [63:0] c[9];
		logic signed [127:0] det;
		logic [127:0] dmag, lim, n, q;
		logic [31:0] r[9];
		logic neg, sat;
		out_word_t o;
		a = '{w.m00, w.m01, w.m02, w.m10, w.m11, w.m12, w.m20, w.m21, w.m22};
		for (int k = 0; k < 9; k++)
			c[k] = 64'(a[COF_IDX[k][0]]) * 64'(a[COF_IDX[k][1]])
				- 64'(a[COF_IDX[k][2]]) * 64'(a[COF_IDX[k][3]]);
		det = 128'(a[0]) * 128'(c[0]) + 128'(a[1]) * 128'(c[3])
			+ 128'(a[2]) * 128'(c[6]);
		dmag = det[127] ? -det : det;
		lim = {96'd0, thr} << 32;
		o = '0;
		if (lim >= dmag) begin
			o.r00 = w.m00; o.r01 = w.m01; o.r02 = w.m02;
			o.r10 = w.m10; o.r11 = w.m11; o.r12 = w.m12;
			o.r20 = w.m20; o.r21 = w.m21; o.r22 = w.m22;
			o.singular = 1'b1;
			return o;
		end
		sat = 1'b0;
		for (int k = 0; k < 9; k++) begin
			neg = c[k][63] != det[127];
			n = (c[k][63] ? -128'(c[k]) : 128'(c[k])) << 32;
			q = n / dmag;
			if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
				sat = 1'b1;
				r[k] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else
				r[k] = neg ? -q[31:0] : q[31:0];
		end
		o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
		o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
		o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
		o.saturated = sat;
		return o;
	endfunction

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 131072)) - 65536);
			3: return 32'($signed($urandom_range(0, 4096)) - 2048);
			4: return 32'h0001_0000;
			5: return 32'($signed($urandom_range(0, 2097152)) - 1048576) << 6;
			default: return $urandom();
		endcase
	endfunction

	function automatic in_word_t rand_mat();
		in_word_t w;
		logic [31:0] e[9];
		for (int k = 0; k < 9; k++)
			e[k] = rand_elem();
		if ($urandom_range(0, 5) == 0) begin
			for (int k = 0; k < 3; k++)
				e[6 + k] = e[3 + k];
		end
		w = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return w;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (push && !full) begin
			inverse_q.push_back(invert(item, threshold));
			void'(pending_mats.pop_front());
		end
		if (cfg_valid && cfg_ready) begin
			threshold <= cfg_data;
			cfg_done <= 1'b1;
		end
		if (cfg_req && !cfg_done && !(cfg_valid && cfg_ready)) begin
			cfg_valid <= 1'b1;
			cfg_data <= cfg_value;
		end else
			cfg_valid <= 1'b0;
		if (push_gap > 0) begin
			push_gap <= push_gap - 1;
			push <= 1'b0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			push_gap <= $urandom_range(0, 10);
			push <= 1'b0;
		end else begin
			// the accepted word is already off the pending queue here
			automatic int n = pending_mats.size();
			push <= arst_n && !cfg_req && n > 0;
			if (n > 0)
				item <= pending_mats[0];
		end
	end

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (inverse_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word %h", result);
			end else begin
				automatic out_word_t e = inverse_q.pop_front();
				if (result !== e) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %h got %h", e, result);
				end
			end
		end
		if (pop_gap > 0) begin
			pop_gap <= pop_gap - 1;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			pop_gap <= $urandom_range(0, 10);
			pop <= 1'b0;
		end else
			pop <= 1'b1;
	end

	always @(posedge clk)
		if (cycles > 2000000) begin
			$display("FAILURE");
			$finish;
		end

	task automatic drain();
		while (pending_mats.size() > 0 || push || inverse_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_threshold(logic [31:0] v);
		drain();
		cfg_value = v;
		cfg_done = 1'b0;
		cfg_req = 1'b1;
		while (!cfg_done)
			@(posedge clk);
		cfg_req = 1'b0;
	endtask

	initial begin
		in_word_t w;
		logic [31:0] thr_set[5];
		repeat (6) @(posedge clk);
		arst_n = 1'b1;
		w = '0;
		pending_mats.push_back(w);
		w = {32'h10000, 32'd0, 32'd0, 32'd0, 32'h10000, 32'd0, 32'd0, 32'd0, 32'h10000};
		pending_mats.push_back(w);
		w = {32'h1, 32'd0, 32'd0, 32'd0, 32'h1, 32'd0, 32'd0, 32'd0, 32'h1};
		pending_mats.push_back(w);
		w = {32'h100, 32'd0, 32'd0, 32'd0, 32'h100, 32'd0, 32'd0, 32'd0, 32'h100};
		pending_mats.push_back(w);
		w = {32'h80000000, 32'd0, 32'd0, 32'd0, 32'h80000000, 32'd0,
			32'd0, 32'd0, 32'h80000000};
		pending_mats.push_back(w);
		w = {32'h7FFFFFFF, 32'd0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd0,
			32'd0, 32'd0, 32'h7FFFFFFF};
		pending_mats.push_back(w);
		w = {32'hFFFF0000, 32'h20000, 32'd0, 32'h30000, 32'h10000, 32'd0,
			32'd0, 32'd0, 32'hFFFF8000};
		pending_mats.push_back(w);
		w = {9{32'hFFFFFFFF}};
		pending_mats.push_back(w);
		w = {9{32'h7FFFFFFF}};
		pending_mats.push_back(w);
		for (int k = 0; k < 8; k++)
			pending_mats.push_back(rand_mat());
		drain();
		thr_set = '{32'd0, 32'hFFFFFFFF, 32'h10000, 32'd1, $urandom()};
		for (int p = 0; p < 5; p++) begin
			write_threshold(thr_set[p]);
			if (p == 4)
				quiet = 1'b1;
			for (int k = 0; k < 150; k++)
				pending_mats.push_back(rand_mat());
		end
		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
